FILE: rtl/core/pump_motor_plant_model_step_defines.svh
// Assertion macros shared by the pump plant model RTL.
// Used by the files that carry concurrent checks; no other dependencies.
`ifndef PUMP_MOTOR_PLANT_MODEL_STEP_DEFINES_SVH
`define PUMP_MOTOR_PLANT_MODEL_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define PMP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pmp check failed");
`define PMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmp check failed");
`else
`define PMP_ASSERT(label, clk, rst, prop)
`define PMP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/pmp_pkg.sv
// Package for the pump plant model: widths, constants, codes, item types,
// CORDIC arctangent table. No dependencies.
package pmp_pkg;

   localparam int PHASE_BITS_DEF = 32;
   localparam int SINE_ITER_DEF  = 16;
   localparam int ITER_IDX_W     = 5;

   localparam int REQ_W      = 16;
   localparam int RSP_W      = 112;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [31:0] SLOW_INC32 = 32'd34178264;
   localparam logic [31:0] JIT_INC32  = 32'd478495693;
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

   localparam logic [16:0] SPEED_FULL = 17'd65536;
   localparam logic [23:0] TEMP_RESET = 24'd1638400;
   localparam logic [23:0] TEMP_MAX   = 24'hFF_FFFF;
   localparam logic [39:0] RUN_MAX    = 40'hFF_FFFF_FFFF;
   localparam logic [14:0] HOUR_DIV   = 15'd28125;
   localparam logic [34:0] HOURS_MAX  = 35'((64'hFF_FFFF_FFFF * 64'd512) / 64'd28125);
   localparam logic [14:0] HREM_MAX   = 15'((64'hFF_FFFF_FFFF * 64'd512) % 64'd28125);

   // reciprocals: x/100 = (x*M100)>>30, x/10 = (x*M10)>>20, x/28125 = (x*M28125)>>42
   localparam logic [23:0] M100   = 24'd10737419;
   localparam logic [16:0] M10    = 17'd104858;
   localparam logic [27:0] M28125 = 28'd156374991;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERVAL = 3'd0,
      CSR_DUTY     = 3'd1,
      CSR_OVERTEMP = 3'd2,
      CSR_RAMP     = 3'd3,
      CSR_THERMAL  = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      MD_STOP     = 2'd0,
      MD_AUTO     = 2'd1,
      MD_HAND     = 2'd2,
      MD_AUTO_ALT = 2'd3
   } mode_type;

   typedef struct packed {
      logic       active;
      logic       manual;
      logic [6:0] sp;
   } item_type;

   typedef struct packed {
      logic               done;
      logic signed [17:0] sine;
   } sine_rsp_type;

   function automatic logic [29:0] atan_turn(input logic [ITER_IDX_W-1:0] i);
      logic [29:0] a;
      unique case (i)
         5'd0:  a = 30'd536870912;
         5'd1:  a = 30'd316933406;
         5'd2:  a = 30'd167458907;
         5'd3:  a = 30'd85004756;
         5'd4:  a = 30'd42667331;
         5'd5:  a = 30'd21354465;
         5'd6:  a = 30'd10679838;
         5'd7:  a = 30'd5340245;
         5'd8:  a = 30'd2670163;
         5'd9:  a = 30'd1335087;
         5'd10: a = 30'd667544;
         5'd11: a = 30'd333772;
         5'd12: a = 30'd166886;
         5'd13: a = 30'd83443;
         5'd14: a = 30'd41722;
         5'd15: a = 30'd20861;
         5'd16: a = 30'd10430;
         5'd17: a = 30'd5215;
         5'd18: a = 30'd2608;
         5'd19: a = 30'd1304;
         5'd20: a = 30'd652;
         5'd21: a = 30'd326;
         5'd22: a = 30'd163;
         5'd23: a = 30'd81;
         default: a = 30'd0;
      endcase
      return a;
   endfunction

endpackage

FILE: rtl/core/pmp_cordic.sv
// Iterative rotation-mode CORDIC giving a Q16 sine of a phase word.
// Depends on pmp_pkg.
module pmp_cordic import pmp_pkg::*; #(
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SINE_ITERATIONS = SINE_ITER_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [PHASE_BITS-1:0] phase,
   output sine_rsp_type          rsp
);

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_RUN  = 3'b010,
      C_OUT  = 3'b100
   } cstate_type;

   localparam logic [ITER_IDX_W-1:0] LAST = ITER_IDX_W'(SINE_ITERATIONS - 1);

   cstate_type state_ff, state_in;
   logic [ITER_IDX_W-1:0] idx_ff, idx_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;

   logic [31:0] u;
   logic signed [33:0] z_init, z_fold, x_sh, y_sh, at, y_mag, r_mag;

   always_comb begin
      u      = 32'(phase) << (32 - PHASE_BITS);
      z_init = 34'(signed'(u));
      // fold into the right half-plane
      if (z_init > 34'sd1073741824) begin
         z_fold = 34'sd2147483648 - z_init;
      end else if (z_init < -34'sd1073741824) begin
         z_fold = -34'sd2147483648 - z_init;
      end else begin
         z_fold = z_init;
      end
      x_sh = x_ff >>> idx_ff;
      y_sh = y_ff >>> idx_ff;
      at   = $signed({4'b0000, atan_turn(idx_ff)});

      state_in = state_ff;
      idx_in   = idx_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               x_in     = CORDIC_X0;
               y_in     = '0;
               z_in     = z_fold;
               idx_in   = '0;
               state_in = C_RUN;
            end
         end
         C_RUN: begin
            if (z_ff >= 0) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + at;
            end
            if (idx_ff == LAST) begin
               state_in = C_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         C_OUT: state_in = C_IDLE;
         default: state_in = C_IDLE;
      endcase

      // y / 16384 rounded half away from zero, limited to +-1.0
      y_mag = y_ff[33] ? -y_ff : y_ff;
      r_mag = (y_mag + 34'sd8192) >>> 14;
      if (r_mag > 34'sd65536) r_mag = 34'sd65536;
      rsp.done = (state_ff == C_OUT);
      rsp.sine = y_ff[33] ? -18'(r_mag) : 18'(r_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

endmodule

FILE: rtl/core/pmp_front.sv
// Request front end: decodes run command and mode, caps the setpoint and
// queues the request in a two-entry FIFO. Depends on pmp_pkg.
`include "pump_motor_plant_model_step_defines.svh"
module pmp_front import pmp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             pop,
   output logic             item_valid,
   output item_type         item
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push;
   mode_type   mode;
   item_type   cls;

   always_comb begin
      mode       = mode_type'(req_tdata[2:1]);
      cls.active = req_tdata[0] && (mode != MD_STOP);
      cls.manual = (mode == MD_HAND);
      cls.sp     = (req_tdata[10:3] > 8'd100) ? 7'd100 : req_tdata[9:3];
      req_tready = (count_ff != 2'd2);
      push       = req_tvalid && req_tready;
      item_valid = (count_ff != 2'd0);
      item       = mem_ff[rd_ptr_ff];
      count_in   = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= cls;
   end

   `PMP_ASSERT(a_cnt_max, clock, reset, count_ff <= 2'd2)
   `PMP_ASSERT(a_pop_nonempty, clock, reset, !pop || count_ff != 2'd0)
   `PMP_ASSERT_NEXT(a_push_grow, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

FILE: rtl/core/pmp_back.sv
// Plant update sequencer: registers, speed ramp, derived outputs, thermal
// model, run hours and the result register. Depends on pmp_pkg, pmp_cordic.
`include "pump_motor_plant_model_step_defines.svh"
module pmp_back import pmp_pkg::*; #(
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SINE_ITERATIONS = SINE_ITER_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  item_valid,
   input  item_type              item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   typedef enum logic [14:0] {
      B_IDLE  = 15'b000000000000001,
      B_SLOW  = 15'b000000000000010,
      B_JGO   = 15'b000000000000100,
      B_JIT   = 15'b000000000001000,
      B_CMD   = 15'b000000000010000,
      B_RAMP  = 15'b000000000100000,
      B_SPD   = 15'b000000001000000,
      B_MUL   = 15'b000000010000000,
      B_FLOW  = 15'b000000100000000,
      B_PRES  = 15'b000001000000000,
      B_THERM = 15'b000010000000000,
      B_TEMP  = 15'b000100000000000,
      B_VIB   = 15'b001000000000000,
      B_HOURS = 15'b010000000000000,
      B_DONE  = 15'b100000000000000
   } bstate_type;

   localparam logic [PHASE_BITS-1:0] SLOW_INC = PHASE_BITS'(SLOW_INC32 >> (32 - PHASE_BITS));
   localparam logic [PHASE_BITS-1:0] JIT_INC  = PHASE_BITS'(JIT_INC32 >> (32 - PHASE_BITS));

   // configuration
   logic [15:0] interval_ff, overtemp_ff;
   logic [6:0]  duty_ff;
   logic [16:0] rgain_ff, tgain_ff;

   // plant state
   bstate_type state_ff, state_in;
   logic [16:0] spd_ff, spd_in;
   logic [23:0] temp_ff, temp_in;
   logic [39:0] rt_ff, rt_in;
   logic [34:0] hours_ff, hours_in;
   logic [14:0] hrem_ff, hrem_in;
   logic [PHASE_BITS-1:0] slow_ph_ff, slow_ph_in, jit_ph_ff, jit_ph_in;

   // per-request working registers
   logic        act_ff, act_in, man_ff, man_in;
   logic [6:0]  sp_ff, sp_in;
   logic signed [17:0] slow_ff, slow_in, jit_ff, jit_in;
   logic [16:0] cmd_ff, cmd_in;
   logic signed [35:0] rprod_ff, rprod_in;
   logic signed [10:0] jd_ff, jd_in;
   logic [16:0] f_ff, f_in;
   logic [32:0] ss_ff, ss_in;
   logic [31:0] sc_ff, sc_in;
   logic [15:0] flow_ff, flow_in;
   logic [19:0] rpm_ff, rpm_in;
   logic [49:0] pp_ff, pp_in;
   logic [10:0] pres_ff, pres_in;
   logic signed [42:0] tprod_ff, tprod_in;
   logic [14:0] t8_ff, t8_in;
   logic        fault_ff, fault_in;
   logic [13:0] va_ff, va_in;
   logic        vneg_ff, vneg_in;
   logic signed [11:0] vib_ff, vib_in;
   logic [24:0] d_ff, d_in;
   logic [10:0] hq_ff, hq_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // cordic
   logic                  sin_start;
   logic [PHASE_BITS-1:0] sin_phase;
   sine_rsp_type          sin_rsp;

   // combinational temporaries
   logic signed [25:0] pct_raw;
   logic [22:0] pct;
   logic [46:0] cmd_prod, jprod;
   logic [16:0] rg_sat, tg_sat, jmag;
   logic signed [17:0] rerr;
   logic signed [35:0] rmag, rround;
   logic signed [18:0] rdelta;
   logic signed [19:0] spd_sum;
   logic [16:0] spd_cl;
   logic [48:0] fprod;
   logic [31:0] rpm_prod;
   logic [51:0] p3;
   logic [23:0] tgt;
   logic signed [25:0] terr;
   logic signed [42:0] tmag, tround;
   logic signed [27:0] tsum;
   logic [23:0] tnew;
   logic [24:0] t8_sum;
   logic [21:0] vsum;
   logic signed [31:0] vn;
   logic [31:0] vmag;
   logic [30:0] vprod;
   logic [52:0] hprod;
   logic [24:0] hrem_d;
   logic [40:0] rt_sum;
   logic [15:0] r2;

   pmp_cordic #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ITERATIONS(SINE_ITERATIONS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .start(sin_start),
      .phase(sin_phase),
      .rsp  (sin_rsp)
   );

   always_comb begin
      rg_sat = (rgain_ff > SPEED_FULL) ? SPEED_FULL : rgain_ff;
      tg_sat = (tgain_ff > SPEED_FULL) ? SPEED_FULL : tgain_ff;

      // commanded percent in Q16, clamped, then /100
      if (!act_ff) begin
         pct_raw = '0;
      end else if (man_ff) begin
         pct_raw = $signed({3'b000, sp_ff, 16'h0000});
      end else begin
         pct_raw = $signed({3'b000, duty_ff, 16'h0000}) + (26'(slow_ff) <<< 2) + 26'(slow_ff);
      end
      if (pct_raw < 26'sd0) begin
         pct = '0;
      end else if (pct_raw > 26'sd6553600) begin
         pct = 23'd6553600;
      end else begin
         pct = 23'(pct_raw);
      end
      cmd_prod = 47'(pct + 23'd50) * 47'(M100);

      rerr = $signed({1'b0, cmd_ff}) - $signed({1'b0, spd_ff});
      rmag   = rprod_ff[35] ? -rprod_ff : rprod_ff;
      rround = (rmag + 36'sd32768) >>> 16;
      rdelta = rprod_ff[35] ? -19'(rround) : 19'(rround);
      spd_sum = $signed({3'b000, spd_ff}) + 20'(rdelta);
      if (spd_sum < 20'sd0) begin
         spd_cl = '0;
      end else if (spd_sum > 20'sd65536) begin
         spd_cl = SPEED_FULL;
      end else begin
         spd_cl = 17'(spd_sum);
      end
      // snap to zero below 0.05 percent
      if (spd_cl <= 17'd32) spd_cl = '0;

      jmag  = jit_ff[17] ? 17'(-jit_ff) : 17'(jit_ff);
      jprod = 47'(jmag + 17'd50) * 47'(M100);

      fprod    = 49'(sc_ff) * 49'(f_ff);
      rpm_prod = 32'(spd_ff) * 32'd2900 + 32'd128;
      p3       = 52'(pp_ff) + (52'(pp_ff) << 1);

      tgt  = TEMP_RESET + 24'(spd_ff) * 24'd70;
      terr = $signed({2'b00, tgt}) - $signed({2'b00, temp_ff});
      tmag   = tprod_ff[42] ? -tprod_ff : tprod_ff;
      tround = (tmag + 43'sd32768) >>> 16;
      tsum   = $signed({4'b0000, temp_ff}) + (tprod_ff[42] ? -28'(tround) : 28'(tround));
      if (tsum < 28'sd0) begin
         tnew = '0;
      end else if (tsum > $signed({4'b0000, TEMP_MAX})) begin
         tnew = TEMP_MAX;
      end else begin
         tnew = 24'(tsum);
      end
      t8_sum = 25'(tnew) + 25'd128;

      vsum = 22'd196608 + 22'(spd_ff) * 22'd38;
      vn   = ((spd_ff != '0) ? $signed({2'b00, vsum, 8'h00}) : 32'sd0) + (32'(jit_ff) <<< 7);
      vmag = vn[31] ? 32'(-vn) : 32'(vn);
      vprod = 31'(va_ff) * 31'(M10);

      hprod  = 53'({interval_ff, 9'b0}) * 53'(M28125);
      hrem_d = d_ff - 25'(hq_ff) * 25'd28125;
      rt_sum = 41'(rt_ff) + 41'(interval_ff);
      r2     = 16'(hrem_ff) + 16'(hrem_d[14:0]);

      state_in   = state_ff;
      spd_in     = spd_ff;
      temp_in    = temp_ff;
      rt_in      = rt_ff;
      hours_in   = hours_ff;
      hrem_in    = hrem_ff;
      slow_ph_in = slow_ph_ff;
      jit_ph_in  = jit_ph_ff;
      act_in = act_ff;   man_in = man_ff;   sp_in = sp_ff;
      slow_in = slow_ff; jit_in = jit_ff;   cmd_in = cmd_ff;
      rprod_in = rprod_ff; jd_in = jd_ff;   f_in = f_ff;
      ss_in = ss_ff;     sc_in = sc_ff;     flow_in = flow_ff;
      rpm_in = rpm_ff;   pp_in = pp_ff;     pres_in = pres_ff;
      tprod_in = tprod_ff; t8_in = t8_ff;   fault_in = fault_ff;
      va_in = va_ff;     vneg_in = vneg_ff; vib_in = vib_ff;
      d_in = d_ff;       hq_in = hq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop       = 1'b0;
      sin_start = 1'b0;
      sin_phase = slow_ph_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (item_valid) begin
               pop       = 1'b1;
               sin_start = 1'b1;
               act_in    = item.active;
               man_in    = item.manual;
               sp_in     = item.sp;
               state_in  = B_SLOW;
            end
         end
         B_SLOW: begin
            if (sin_rsp.done) begin
               slow_in  = sin_rsp.sine;
               state_in = B_JGO;
            end
         end
         B_JGO: begin
            sin_start = 1'b1;
            sin_phase = jit_ph_ff;
            state_in  = B_JIT;
         end
         B_JIT: begin
            if (sin_rsp.done) begin
               jit_in   = sin_rsp.sine;
               state_in = B_CMD;
            end
         end
         B_CMD: begin
            cmd_in   = cmd_prod[46:30];
            state_in = B_RAMP;
         end
         B_RAMP: begin
            rprod_in = 36'(rerr) * 36'($signed({1'b0, rg_sat}));
            state_in = B_SPD;
         end
         B_SPD: begin
            spd_in   = spd_cl;
            jd_in    = jit_ff[17] ? -11'(jprod[39:30]) : 11'(jprod[39:30]);
            state_in = B_MUL;
         end
         B_MUL: begin
            f_in     = 17'(18'sd65536 + 18'(jd_ff));
            ss_in    = 33'(spd_ff) * 33'(spd_ff);
            sc_in    = 32'(spd_ff) * 32'd38400;
            state_in = B_FLOW;
         end
         B_FLOW: begin
            flow_in  = fprod[47:32];
            rpm_in   = rpm_prod[27:8];
            state_in = B_PRES;
         end
         B_PRES: begin
            pp_in    = 50'(ss_ff) * 50'(f_ff);
            state_in = B_THERM;
         end
         B_THERM: begin
            pres_in  = p3[49:39];
            tprod_in = 43'(terr) * 43'($signed({1'b0, tg_sat}));
            state_in = B_TEMP;
         end
         B_TEMP: begin
            temp_in  = tnew;
            t8_in    = (t8_sum[24:8] > 17'd32767) ? 15'd32767 : t8_sum[22:8];
            fault_in = (tnew > {overtemp_ff, 8'h00});
            va_in    = 14'((vmag + 32'd327680) >> 16);
            vneg_in  = vn[31];
            state_in = B_VIB;
         end
         B_VIB: begin
            vib_in   = vneg_ff ? -$signed({1'b0, vprod[30:20]}) : $signed({1'b0, vprod[30:20]});
            d_in     = {interval_ff, 9'b0};
            hq_in    = hprod[52:42];
            state_in = B_HOURS;
         end
         B_HOURS: begin
            if (act_ff) begin
               if (rt_sum > 41'(RUN_MAX)) begin
                  rt_in    = RUN_MAX;
                  hours_in = HOURS_MAX;
                  hrem_in  = HREM_MAX;
               end else begin
                  rt_in = rt_sum[39:0];
                  if (r2 >= 16'(HOUR_DIV)) begin
                     hrem_in  = 15'(r2 - 16'(HOUR_DIV));
                     hours_in = hours_ff + 35'(hq_ff) + 35'd1;
                  end else begin
                     hrem_in  = r2[14:0];
                     hours_in = hours_ff + 35'(hq_ff);
                  end
               end
            end
            slow_ph_in = slow_ph_ff + SLOW_INC;
            jit_ph_in  = jit_ph_ff + JIT_INC;
            state_in   = B_DONE;
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, fault_ff, hours_ff, vib_ff, rpm_ff, t8_ff, pres_ff,
                               flow_ff};
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         spd_ff       <= '0;
         temp_ff      <= TEMP_RESET;
         rt_ff        <= '0;
         hours_ff     <= '0;
         hrem_ff      <= '0;
         slow_ph_ff   <= '0;
         jit_ph_ff    <= '0;
         interval_ff  <= 16'd1000;
         duty_ff      <= 7'd75;
         overtemp_ff  <= 16'd21760;
         rgain_ff     <= 17'd16384;
         tgain_ff     <= 17'd1966;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         spd_ff       <= spd_in;
         temp_ff      <= temp_in;
         rt_ff        <= rt_in;
         hours_ff     <= hours_in;
         hrem_ff      <= hrem_in;
         slow_ph_ff   <= slow_ph_in;
         jit_ph_ff    <= jit_ph_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_INTERVAL: interval_ff <= csr_wdata[15:0];
               CSR_DUTY:     duty_ff     <= csr_wdata[6:0];
               CSR_OVERTEMP: overtemp_ff <= csr_wdata[15:0];
               CSR_RAMP:     rgain_ff    <= csr_wdata;
               CSR_THERMAL:  tgain_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
      act_ff <= act_in;   man_ff <= man_in;   sp_ff <= sp_in;
      slow_ff <= slow_in; jit_ff <= jit_in;   cmd_ff <= cmd_in;
      rprod_ff <= rprod_in; jd_ff <= jd_in;   f_ff <= f_in;
      ss_ff <= ss_in;     sc_ff <= sc_in;     flow_ff <= flow_in;
      rpm_ff <= rpm_in;   pp_ff <= pp_in;     pres_ff <= pres_in;
      tprod_ff <= tprod_in; t8_ff <= t8_in;   fault_ff <= fault_in;
      va_ff <= va_in;     vneg_ff <= vneg_in; vib_ff <= vib_in;
      d_ff <= d_in;       hq_ff <= hq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `PMP_ASSERT(a_spd_range, clock, reset, spd_ff <= SPEED_FULL)
   `PMP_ASSERT_NEXT(a_pop_starts, clock, reset, pop, state_ff == B_SLOW)
   `PMP_ASSERT_NEXT(a_run_sat_holds, clock, reset, rt_ff == RUN_MAX, rt_ff == RUN_MAX)
   `PMP_ASSERT_NEXT(a_done_waits, clock, reset, state_ff == B_DONE && rsp_valid_ff && !rsp_tready, state_ff == B_DONE)

endmodule

FILE: rtl/core/pump_motor_plant_model_step.sv
// Channel  | Dir | Payload (low bit first)
// req      | in  | running, mode[2], setpoint[8]
// rsp      | out | flow_q8, pressure_q8, motor_temp_q8, rpm_q8, vibration_q8,
//          |     | hours_q16, overtemp_fault
// csr      | in  | write enable, register index, write data
// The single CORDIC unit, run once per sine, sets most of the time that a
// request takes.
// The front queue holds two requests, so requests are taken while the
// sequencer works and while a result waits. Reset is synchronous and
// restores register defaults and the plant state.
module pump_motor_plant_model_step import pmp_pkg::*; #(
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SINE_ITERATIONS = SINE_ITER_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // running, mode[1:0], setpoint[7:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // flow_q8[15:0], pressure_q8[10:0],
                                              // motor_temp_q8[14:0], rpm_q8[19:0],
                                              // vibration_q8[11:0], hours_q16[34:0],
                                              // overtemp_fault
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic     item_valid, pop;
   item_type item;

   pmp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .pop       (pop),
      .item_valid(item_valid),
      .item      (item)
   );

   pmp_back #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ITERATIONS(SINE_ITERATIONS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .item_valid(item_valid),
      .item      (item),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule
